>>> hw/rtl/rbsi_pkg.sv
// Shared widths, register indexes and pipeline types for the ray/box slab tester.
package rbsi_pkg;

  localparam int COORD_W  = 32;
  localparam int DIR_W    = 16;
  localparam int LEN_W    = 31;
  localparam int DIR_FRAC = 14;
  localparam int MAG_W    = 33;

  localparam logic signed [DIR_W-1:0] DIR_ONE     = 16'sd16384;
  localparam logic signed [DIR_W-1:0] DIR_NEG_ONE = -16'sd16384;
  localparam logic signed [DIR_W-1:0] DIR_MAX     = 16'sd32767;
  localparam logic signed [DIR_W-1:0] DIR_MIN     = -16'sd32768;

  typedef enum logic [2:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_START_Z = 3'd2,
    REG_DIR_X   = 3'd3,
    REG_DIR_Y   = 3'd4,
    REG_DIR_Z   = 3'd5,
    REG_LEN     = 3'd6
  } reg_idx_e;

  // Per-item flags that ride alongside the dividers.
  typedef struct packed {
    logic       miss;
    logic       in_box;
    logic [2:0] dz;
    logic [5:0] neg;
  } side_t;

endpackage

>>> hw/rtl/rbsi_div.sv
// Pipelined restoring divider: one quotient bit per stage, quotient overflow flag.
module rbsi_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic [FRAC_BITS+1:0]           en_i,
  input  logic [rbsi_pkg::MAG_W-1:0]     mag_i,
  input  logic [rbsi_pkg::MAG_W-1:0]     div_i,
  output logic [FRAC_BITS+1:0]           quot_o,
  output logic                           rem_nz_o,
  output logic                           ovf_o
);

  localparam int QW = FRAC_BITS + 2;
  localparam int MW = rbsi_pkg::MAG_W;

  logic [MW-1:0] r_q   [QW];
  logic [MW-1:0] d_q   [QW];
  logic [QW-1:0] lo_q  [QW];
  logic [QW-1:0] quo_q [QW];
  logic          ovf_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [MW-1:0] r_in, d_in;
    logic [QW-1:0] lo_in, q_in;
    logic          ovf_in;
    logic [MW:0]   rs;
    logic          ge;

    if (j == 0) begin : g_first
      // dividend is mag << FRAC_BITS; quotient fits QW bits unless mag >= 4*div
      assign r_in   = {2'b00, mag_i[MW-1:2]};
      assign lo_in  = {mag_i[1:0], {FRAC_BITS{1'b0}}};
      assign q_in   = '0;
      assign d_in   = div_i;
      assign ovf_in = ({2'b00, mag_i} >= {div_i, 2'b00});
    end else begin : g_next
      assign r_in   = r_q[j-1];
      assign lo_in  = lo_q[j-1];
      assign q_in   = quo_q[j-1];
      assign d_in   = d_q[j-1];
      assign ovf_in = ovf_q[j-1];
    end

    assign rs = {r_in, lo_in[QW-1]};
    assign ge = (rs >= {1'b0, d_in});

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        r_q[j]   <= ge ? MW'(rs - {1'b0, d_in}) : MW'(rs);
        d_q[j]   <= d_in;
        lo_q[j]  <= {lo_in[QW-2:0], 1'b0};
        quo_q[j] <= {q_in[QW-2:0], ge};
        ovf_q[j] <= ovf_in;
      end
    end
  end

  assign quot_o   = quo_q[QW-1];
  assign rem_nz_o = (r_q[QW-1] != '0);
  assign ovf_o    = ovf_q[QW-1];

endmodule

>>> hw/rtl/ray_box_slab_intersect_3d.sv
// Top level: streaming ray vs axis-aligned box slab test, fixed point, fully pipelined.
//
//  channel   dir  handshake             payload
//  -------   ---  --------------------  ------------------------------------------
//  box       in   in_valid_i/in_ready_o box_min_{x,y,z}_i, box_max_{x,y,z}_i
//  result    out  out_valid_o/out_ready_i hit_o, impact_length_o, impact_*_o, normal_*_o
//  config    in   APB (psel..pready)    ray start, direction, max length
//
// One request enters per cycle while in_ready_o is high; FRAC_BITS+9 register stages
// (25 at the default) lie between an accepted box and its result. Most of that
// depth is the slab dividers, which resolve one quotient bit per stage.
// Each stage holds its request until the next stage frees up, so bubbles are
// squeezed out and a waiting result stops new boxes only once every stage is full.
// Reset clears the valid bits and loads the config defaults (+x, length 1.0).
module ray_box_slab_intersect_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] box_min_x_i,
  input  logic signed [31:0] box_min_y_i,
  input  logic signed [31:0] box_min_z_i,
  input  logic signed [31:0] box_max_x_i,
  input  logic signed [31:0] box_max_y_i,
  input  logic signed [31:0] box_max_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic [30:0]        impact_length_o,
  output logic signed [31:0] impact_x_o,
  output logic signed [31:0] impact_y_o,
  output logic signed [31:0] impact_z_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o
);

  localparam int QW = FRAC_BITS + 2;   // quotient bits / divider stages
  localparam int TW = FRAC_BITS + 4;   // clamped slab parameter width
  localparam int ND = 1 + QW;          // index of last divider stage
  localparam int NS = ND + 6;          // total stages
  localparam int SA = ND + 1;
  localparam int SB = ND + 2;
  localparam int SC = ND + 3;
  localparam int SD = ND + 4;
  localparam int SE = ND + 5;
  localparam int CW = rbsi_pkg::COORD_W;
  localparam int DW = rbsi_pkg::DIR_W;
  localparam int LW = rbsi_pkg::LEN_W;
  localparam int MW = rbsi_pkg::MAG_W;
  localparam int PW = DW + LW + 1;     // direction * length product

  // Slab parameters beyond +/-(1.0 + lsb) are clamped: any box that needs them
  // misses anyway, and the clamp keeps every ordering that can matter.
  localparam logic signed [TW-1:0] T_ONE = TW'(1 << FRAC_BITS);
  localparam logic signed [TW-1:0] T_LIM = TW'((1 << FRAC_BITS) + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] start_q [3];
  logic signed [DW-1:0] dir_q   [3];
  logic [LW-1:0]        len_q;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q[0] <= '0;
      start_q[1] <= '0;
      start_q[2] <= '0;
      dir_q[0]   <= rbsi_pkg::DIR_ONE;
      dir_q[1]   <= '0;
      dir_q[2]   <= '0;
      len_q      <= LW'(65536);
    end else if (wr_en) begin
      unique case (rbsi_pkg::reg_idx_e'(paddr[4:2]))
        rbsi_pkg::REG_START_X: start_q[0] <= pwdata;
        rbsi_pkg::REG_START_Y: start_q[1] <= pwdata;
        rbsi_pkg::REG_START_Z: start_q[2] <= pwdata;
        rbsi_pkg::REG_DIR_X:   dir_q[0]   <= pwdata[DW-1:0];
        rbsi_pkg::REG_DIR_Y:   dir_q[1]   <= pwdata[DW-1:0];
        rbsi_pkg::REG_DIR_Z:   dir_q[2]   <= pwdata[DW-1:0];
        rbsi_pkg::REG_LEN:     len_q      <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (rbsi_pkg::reg_idx_e'(paddr[4:2]))
      rbsi_pkg::REG_START_X: prdata = start_q[0];
      rbsi_pkg::REG_START_Y: prdata = start_q[1];
      rbsi_pkg::REG_START_Z: prdata = start_q[2];
      rbsi_pkg::REG_DIR_X:   prdata = 32'(dir_q[0]);
      rbsi_pkg::REG_DIR_Y:   prdata = 32'(dir_q[1]);
      rbsi_pkg::REG_DIR_Z:   prdata = 32'(dir_q[2]);
      rbsi_pkg::REG_LEN:     prdata = {1'b0, len_q};
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage valid bits and advance chain
  // ---------------------------------------------------------------------------
  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: capture box, segment extent products D*L
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] bmin_in [3];
  logic signed [CW-1:0] bmax_in [3];
  logic signed [CW-1:0] s0_bmin_q [3];
  logic signed [CW-1:0] s0_bmax_q [3];
  logic signed [PW-1:0] s0_prod_q [3];

  assign bmin_in[0] = box_min_x_i;
  assign bmin_in[1] = box_min_y_i;
  assign bmin_in[2] = box_min_z_i;
  assign bmax_in[0] = box_max_x_i;
  assign bmax_in[1] = box_max_y_i;
  assign bmax_in[2] = box_max_z_i;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int a = 0; a < 3; a++) begin
        s0_bmin_q[a] <= bmin_in[a];
        s0_bmax_q[a] <= bmax_in[a];
        s0_prod_q[a] <= PW'(dir_q[a]) * $signed({1'b0, len_q});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: overlap, inside and parallel tests; divider operands
  // ---------------------------------------------------------------------------
  rbsi_pkg::side_t      s1_side_d, s1_side_q;
  logic [MW-1:0]        s1_absd_d [3], s1_absd_q [3];
  logic [MW-1:0]        s1_absn_d [6], s1_absn_q [6];

  always_comb begin
    logic signed [33:0] delta;
    logic signed [34:0] sx, ex, lox, hix, mnx, mxx;
    logic signed [32:0] nlo, nhi;
    logic               ovl_miss, in_box, par_miss;
    ovl_miss = 1'b0;
    in_box   = 1'b1;
    par_miss = 1'b0;
    s1_side_d = '0;
    for (int a = 0; a < 3; a++) begin
      delta = s0_prod_q[a][PW-1:rbsi_pkg::DIR_FRAC];
      sx    = 35'(start_q[a]);
      ex    = sx + 35'(delta);
      mnx   = 35'(s0_bmin_q[a]);
      mxx   = 35'(s0_bmax_q[a]);
      lox   = (ex < sx) ? ex : sx;
      hix   = (ex < sx) ? sx : ex;
      if (!(hix > mnx && lox < mxx)) ovl_miss = 1'b1;
      if (!(sx > mnx && sx < mxx)) in_box = 1'b0;
      s1_side_d.dz[a] = (delta == '0);
      if (delta == '0 && (sx <= mnx || sx >= mxx)) par_miss = 1'b1;
      nlo = 33'(s0_bmin_q[a]) - 33'(start_q[a]);
      nhi = 33'(s0_bmax_q[a]) - 33'(start_q[a]);
      s1_absd_d[a]     = delta[33] ? MW'(-delta) : MW'(delta);
      s1_absn_d[2*a]   = nlo[32] ? (~nlo + 33'd1) : nlo;
      s1_absn_d[2*a+1] = nhi[32] ? (~nhi + 33'd1) : nhi;
      s1_side_d.neg[2*a]   = nlo[32] != delta[33];
      s1_side_d.neg[2*a+1] = nhi[32] != delta[33];
    end
    s1_side_d.in_box = !ovl_miss && in_box;
    s1_side_d.miss   = ovl_miss || (!in_box && par_miss);
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_side_q <= s1_side_d;
      s1_absd_q <= s1_absd_d;
      s1_absn_q <= s1_absn_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider stages: six slab parameters, flags carried alongside
  // ---------------------------------------------------------------------------
  logic [QW-1:0] dv_quot [6];
  logic          dv_rnz  [6];
  logic          dv_ovf  [6];

  for (genvar l = 0; l < 6; l++) begin : g_div
    rbsi_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk_i    (clk_i),
      .en_i     (adv[ND:2]),
      .mag_i    (s1_absn_q[l]),
      .div_i    (s1_absd_q[l/2]),
      .quot_o   (dv_quot[l]),
      .rem_nz_o (dv_rnz[l]),
      .ovf_o    (dv_ovf[l])
    );
  end

  rbsi_pkg::side_t sd_q [QW];

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      sd_q[0] <= s1_side_q;
    end
    for (int j = 1; j < QW; j++) begin
      if (adv[2+j]) begin
        sd_q[j] <= sd_q[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: signed, floored, clamped slab parameters
  // ---------------------------------------------------------------------------
  logic signed [TW-1:0] a_t_d [6], a_t_q [6];
  rbsi_pkg::side_t      a_side_q;

  always_comb begin
    logic signed [TW-1:0] mag, t;
    for (int l = 0; l < 6; l++) begin
      mag = dv_ovf[l] ? T_LIM : $signed(TW'(dv_quot[l]));
      if (sd_q[QW-1].neg[l]) begin
        t = -mag - $signed(TW'(dv_rnz[l] && !dv_ovf[l]));
      end else begin
        t = mag;
      end
      if (t > T_LIM) begin
        t = T_LIM;
      end else if (t < -T_LIM) begin
        t = -T_LIM;
      end
      a_t_d[l] = t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[SA]) begin
      a_t_q    <= a_t_d;
      a_side_q <= sd_q[QW-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: slab intersection, face choice, entry range check
  // ---------------------------------------------------------------------------
  logic                 b_miss_d, b_miss_q;
  logic [FRAC_BITS:0]   b_enter_d, b_enter_q;
  logic signed [DW-1:0] b_nrm_d [3], b_nrm_q [3];

  always_comb begin
    logic signed [TW-1:0] enter, exitp, tlo, thi, en, ex;
    logic                 have, m, fneg, lt;
    logic [1:0]           fax;
    enter = '0;
    exitp = '0;
    have  = 1'b0;
    m     = 1'b0;
    fneg  = 1'b0;
    fax   = 2'd0;
    for (int a = 0; a < 3; a++) begin
      tlo = a_t_q[2*a];
      thi = a_t_q[2*a+1];
      lt  = tlo < thi;
      en  = lt ? tlo : thi;
      ex  = lt ? thi : tlo;
      if (!a_side_q.dz[a]) begin
        if (!have) begin
          enter = en;
          exitp = ex;
          fax   = 2'(a);
          fneg  = lt;
          have  = 1'b1;
        end else begin
          if (a < 2) begin
            // tie with the earlier entry keeps the earlier face
            if (!(en < exitp && enter < ex)) m = 1'b1;
            if (enter < en) begin
              fax  = 2'(a);
              fneg = lt;
            end
          end else begin
            // z wins a tie
            if (!(exitp > en && ex > enter)) m = 1'b1;
            if (!(en < enter)) begin
              fax  = 2'(a);
              fneg = lt;
            end
          end
          if (en > enter) enter = en;
          if (ex < exitp) exitp = ex;
        end
      end
    end
    if (!have || enter < 0 || enter > T_ONE) m = 1'b1;

    for (int a = 0; a < 3; a++) begin
      if (fax == 2'(a)) begin
        b_nrm_d[a] = fneg ? rbsi_pkg::DIR_NEG_ONE : rbsi_pkg::DIR_ONE;
      end else begin
        b_nrm_d[a] = '0;
      end
    end
    b_enter_d = enter[FRAC_BITS:0];
    b_miss_d  = m;

    if (a_side_q.miss) begin
      b_miss_d = 1'b1;
    end else if (a_side_q.in_box) begin
      // start inside the box: length 0, normal opposes the ray
      b_miss_d  = 1'b0;
      b_enter_d = '0;
      for (int a = 0; a < 3; a++) begin
        b_nrm_d[a] = (dir_q[a] == rbsi_pkg::DIR_MIN) ? rbsi_pkg::DIR_MAX : -dir_q[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[SB]) begin
      b_miss_q  <= b_miss_d;
      b_enter_q <= b_enter_d;
      b_nrm_q   <= b_nrm_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: impact length = enter * L >> FRAC_BITS
  // ---------------------------------------------------------------------------
  logic [FRAC_BITS+LW:0] c_prod;
  logic [LW-1:0]         c_len_q;
  logic                  c_miss_q;
  logic signed [DW-1:0]  c_nrm_q [3];

  assign c_prod = (FRAC_BITS+LW+1)'(b_enter_q) * (FRAC_BITS+LW+1)'(len_q);

  always_ff @(posedge clk_i) begin
    if (adv[SC]) begin
      c_len_q  <= c_prod[FRAC_BITS+LW-1:FRAC_BITS];
      c_miss_q <= b_miss_q;
      c_nrm_q  <= b_nrm_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: D * length products for the impact point
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] d_prod_q [3];
  logic [LW-1:0]        d_len_q;
  logic                 d_miss_q;
  logic signed [DW-1:0] d_nrm_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[SD]) begin
      for (int a = 0; a < 3; a++) begin
        d_prod_q[a] <= PW'(dir_q[a]) * $signed({1'b0, c_len_q});
      end
      d_len_q  <= c_len_q;
      d_miss_q <= c_miss_q;
      d_nrm_q  <= c_nrm_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: saturated impact point, miss zeroing, output register
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] e_pos_d [3], e_pos_q [3];
  logic signed [DW-1:0] e_nrm_q [3];
  logic [LW-1:0]        e_len_q;
  logic                 e_hit_q;

  always_comb begin
    logic signed [34:0] p;
    for (int a = 0; a < 3; a++) begin
      p = 35'(start_q[a]) + 35'($signed(d_prod_q[a][PW-1:rbsi_pkg::DIR_FRAC]));
      if (p > 35'sd2147483647) begin
        e_pos_d[a] = 32'sh7FFFFFFF;
      end else if (p < -35'sd2147483648) begin
        e_pos_d[a] = 32'sh80000000;
      end else begin
        e_pos_d[a] = p[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[SE]) begin
      e_hit_q <= !d_miss_q;
      e_len_q <= d_miss_q ? '0 : d_len_q;
      for (int a = 0; a < 3; a++) begin
        e_pos_q[a] <= d_miss_q ? '0 : e_pos_d[a];
        e_nrm_q[a] <= d_miss_q ? '0 : d_nrm_q[a];
      end
    end
  end

  assign out_valid_o     = v_q[NS-1];
  assign hit_o           = e_hit_q;
  assign impact_length_o = e_len_q;
  assign impact_x_o      = e_pos_q[0];
  assign impact_y_o      = e_pos_q[1];
  assign impact_z_o      = e_pos_q[2];
  assign normal_x_o      = e_nrm_q[0];
  assign normal_y_o      = e_nrm_q[1];
  assign normal_z_o      = e_nrm_q[2];

endmodule

>>> hw/rtl/rbsi_chk.sv
// Port-level checker for the ray/box slab tester, bound to the top level.
module rbsi_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               hit_o,
  input logic [30:0]        impact_length_o,
  input logic signed [31:0] impact_x_o,
  input logic signed [31:0] impact_y_o,
  input logic signed [31:0] impact_z_o,
  input logic signed [15:0] normal_x_o,
  input logic signed [15:0] normal_y_o,
  input logic signed [15:0] normal_z_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) &&
      $stable(impact_length_o) && $stable(impact_x_o) && $stable(normal_x_o))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> impact_length_o == '0 && impact_x_o == '0 &&
      impact_y_o == '0 && impact_z_o == '0 && normal_x_o == '0 &&
      normal_y_o == '0 && normal_z_o == '0)
    else $error("miss result not cleared");

  a_face_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o && impact_length_o != '0 |->
      $countones({normal_x_o != '0, normal_y_o != '0, normal_z_o != '0}) == 1)
    else $error("face hit without a single axis normal");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind ray_box_slab_intersect_3d rbsi_chk u_rbsi_chk (.*);
